/* src/bced_pkg.sv */
// Shared types, constants and helpers of the block-constrained error diffusion unit.
// No dependencies; every RTL file imports this package.
package bced_pkg;

   localparam int CH_W   = 8;
   localparam int RGB_W  = 3 * CH_W;
   localparam int ERR_W  = 14;
   localparam int DIST_W = 18;
   localparam int IDX_W  = 4;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef err_type [2:0]           err3_type;
   typedef logic [RGB_W-1:0]        rgb_type;

   typedef struct packed {
      logic row_last;
      logic frame;
   } blk_flags_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_START,
      BK_LRD,
      BK_LWR,
      BK_DIST,
      BK_SCORE,
      BK_DRAIN,
      BK_DA,
      BK_DB,
      BK_DC,
      BK_FLUSH,
      BK_DONE
   } back_state_type;

   // channel 0 (red) in the low byte
   localparam rgb_type PALETTE_RGB [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'h808080,
      24'hC0C0C0, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   // value in 1/16 units to a 0..255 channel
   function automatic logic [CH_W-1:0] clamp_px(input logic signed [ERR_W:0] v);
      logic signed [ERR_W:0] s;
      s = v >>> 4;
      if (v < 0) begin
         return '0;
      end else if (s > 15'sd255) begin
         return 8'hFF;
      end else begin
         return s[CH_W-1:0];
      end
   endfunction

endpackage

/* src/bced_dist.sv */
// Shared squared RGB distance unit: three 9-bit squares and a sum.
// Depends on bced_pkg.
module bced_dist (
   input  bced_pkg::rgb_type               color,
   input  bced_pkg::rgb_type               pal,
   output logic [bced_pkg::DIST_W-1:0]     dist_sq
);
   import bced_pkg::*;

   logic signed [CH_W:0]     d  [3];
   logic signed [DIST_W-1:0] sq [3];

   always_comb begin
      dist_sq = '0;
      for (int c = 0; c < 3; c++) begin
         d[c]    = $signed({1'b0, color[c*CH_W +: CH_W]}) - $signed({1'b0, pal[c*CH_W +: CH_W]});
         sq[c]   = d[c] * d[c];
         dist_sq = dist_sq + DIST_W'(sq[c][15:0]);
      end
   end

endmodule

/* src/bced_queue.sv */
// Two-slot block queue between the front end and the back end.
// Holds raw pixels and a descriptor per closed block. Depends on bced_pkg.
module bced_queue #(
   parameter int MAX_WIDTH   = 1024,
   parameter int BLOCK_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [$clog2(BLOCK_WIDTH)-1:0]         wr_idx,
   input  bced_pkg::rgb_type                      wr_pix,
   input  logic                                   push,
   input  logic [$clog2(BLOCK_WIDTH+1)-1:0]       push_n,
   input  logic [$clog2(MAX_WIDTH)-1:0]           push_x0,
   input  bced_pkg::blk_flags_type                push_flags,
   input  logic [$clog2(MAX_WIDTH):0]             push_w,
   output logic                                   can_write,
   input  logic [$clog2(BLOCK_WIDTH)-1:0]         rd_idx,
   output bced_pkg::rgb_type                      rd_pix,
   output logic                                   avail,
   input  logic                                   pop,
   output logic [$clog2(BLOCK_WIDTH+1)-1:0]       rd_n,
   output logic [$clog2(MAX_WIDTH)-1:0]           rd_x0,
   output bced_pkg::blk_flags_type                rd_flags,
   output logic [$clog2(MAX_WIDTH):0]             rd_w
);
   import bced_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int FW  = $clog2(BLOCK_WIDTH + 1);

   rgb_type          pix_ff   [2][BLOCK_WIDTH];
   logic [FW-1:0]    n_ff     [2];
   logic [CW-1:0]    x0_ff    [2];
   blk_flags_type    flags_ff [2];
   logic [CW:0]      w_ff     [2];
   logic [1:0]       full_ff;
   logic             wsel_ff;
   logic             rsel_ff;

   assign can_write = !full_ff[wsel_ff];
   assign avail     = full_ff[rsel_ff];
   assign rd_pix    = pix_ff[rsel_ff][rd_idx];
   assign rd_n      = n_ff[rsel_ff];
   assign rd_x0     = x0_ff[rsel_ff];
   assign rd_flags  = flags_ff[rsel_ff];
   assign rd_w      = w_ff[rsel_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
         wsel_ff <= 1'b0;
         rsel_ff <= 1'b0;
      end else begin
         if (push) begin
            full_ff[wsel_ff] <= 1'b1;
            wsel_ff          <= !wsel_ff;
         end
         if (pop) begin
            full_ff[rsel_ff] <= 1'b0;
            rsel_ff          <= !rsel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_ff[wsel_ff][wr_idx] <= wr_pix;
      end
      if (push) begin
         n_ff[wsel_ff]     <= push_n;
         x0_ff[wsel_ff]    <= push_x0;
         flags_ff[wsel_ff] <= push_flags;
         w_ff[wsel_ff]     <= push_w;
      end
   end

endmodule

/* src/bced_front.sv */
// Front end: accepts pixel words, tracks column and block fill, closes blocks.
// Writes into bced_queue. Depends on bced_pkg.
module bced_front #(
   parameter int MAX_WIDTH   = 1024,
   parameter int BLOCK_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  bced_pkg::rgb_type                      req_tdata,
   input  logic                                   req_tuser,
   input  logic [$clog2(MAX_WIDTH):0]             w_eff,
   input  logic                                   q_can_write,
   output logic                                   q_wr_en,
   output logic [$clog2(BLOCK_WIDTH)-1:0]         q_wr_idx,
   output bced_pkg::rgb_type                      q_wr_pix,
   output logic                                   q_push,
   output logic [$clog2(BLOCK_WIDTH+1)-1:0]       q_n,
   output logic [$clog2(MAX_WIDTH)-1:0]           q_x0,
   output bced_pkg::blk_flags_type                q_flags,
   output logic [$clog2(MAX_WIDTH):0]             q_w
);
   import bced_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int FW  = $clog2(BLOCK_WIDTH + 1);
   localparam int BIW = $clog2(BLOCK_WIDTH);

   logic [CW-1:0] col_ff;
   logic [FW-1:0] fill_ff;
   logic          frame_ff;

   logic          accept;
   logic [CW-1:0] x;
   logic [FW-1:0] fill;
   logic [FW-1:0] new_fill;
   logic          row_last;
   logic          close;

   always_comb begin
      accept   = req_tvalid && q_can_write;
      // frame start drops any partial block
      x        = req_tuser ? '0 : col_ff;
      fill     = req_tuser ? '0 : fill_ff;
      new_fill = fill + FW'(1);
      row_last = (WW'(x) + WW'(1)) >= w_eff;
      close    = row_last || (new_fill == FW'(BLOCK_WIDTH));
   end

   assign req_tready      = q_can_write;
   assign q_wr_en         = accept;
   assign q_wr_idx        = fill[BIW-1:0];
   assign q_wr_pix        = req_tdata;
   assign q_push          = accept && close;
   assign q_n             = new_fill;
   assign q_x0            = CW'(WW'(x) - WW'(fill));
   assign q_flags.row_last = row_last;
   assign q_flags.frame   = (fill == '0) ? req_tuser : frame_ff;
   assign q_w             = w_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         fill_ff  <= '0;
         frame_ff <= 1'b0;
      end else if (accept) begin
         col_ff   <= row_last ? '0 : x + CW'(1);
         fill_ff  <= close ? '0 : new_fill;
         frame_ff <= q_flags.frame;
      end
   end

endmodule

/* src/bced_back.sv */
// Back end: per block, loads errors, scores palette pairs, dithers and emits words.
// Holds the ping-pong error memory and the distance memory. Depends on bced_pkg, bced_dist.
module bced_back #(
   parameter int MAX_WIDTH    = 1024,
   parameter int BLOCK_WIDTH  = 8,
   parameter int PALETTE_SIZE = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_avail,
   output logic                                   q_pop,
   output logic [$clog2(BLOCK_WIDTH)-1:0]         q_rd_idx,
   input  bced_pkg::rgb_type                      q_rd_pix,
   input  logic [$clog2(BLOCK_WIDTH+1)-1:0]       q_n,
   input  logic [$clog2(MAX_WIDTH)-1:0]           q_x0,
   input  bced_pkg::blk_flags_type                q_flags,
   input  logic [$clog2(MAX_WIDTH):0]             q_w,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);
   import bced_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int AW  = CW + 1;
   localparam int FW  = $clog2(BLOCK_WIDTH + 1);
   localparam int BIW = $clog2(BLOCK_WIDTH);
   localparam int PW  = $clog2(PALETTE_SIZE);
   localparam int SW  = DIST_W + FW;
   localparam logic [PW-1:0] LAST_P = PW'(PALETTE_SIZE - 1);

   back_state_type state_ff, state_in;

   // error stores, one bank per row; reads past the bank's fill count give zero
   err3_type   err_mem [2**AW];
   err3_type   rdata_ff;
   logic       rd_zero_ff;
   logic       bank_ff;
   logic [WW-1:0] cnt_ff [2];

   logic [BLOCK_WIDTH-1:0][DIST_W-1:0] dist_mem [PALETTE_SIZE];
   logic [BLOCK_WIDTH-1:0][DIST_W-1:0] lane_ff;
   logic [BLOCK_WIDTH-1:0][DIST_W-1:0] lane_in;

   err3_type   v_ff [BLOCK_WIDTH];
   err3_type   rcarry_ff, icarry_ff, acc_a_ff, acc_b_ff;
   err3_type   icarry_in, acc_a_in, acc_b_in, wdata;

   logic [FW-1:0] k_ff;
   logic [PW-1:0] p_ff;
   logic [PW-1:0] si_ff, sj_ff;

   logic [BLOCK_WIDTH-1:0][DIST_W-1:0] rd_i_ff, rd_j_ff;
   logic          s1_valid_ff, s2_valid_ff;
   logic [PW-1:0] s1_i_ff, s1_j_ff, s2_i_ff, s2_j_ff;
   logic [SW-1:0] sum_ff, sum_in, best_ff;
   logic [PW-1:0] best_i_ff, best_j_ff;
   logic          have_ff;

   rgb_type          col_ff, col_a, eff_k;
   logic [DIST_W-1:0] di_ff, dj_ff, dist_o;
   rgb_type          dist_color, dist_pal, pal_pick;
   logic [PW-1:0]    pick;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_bend_ff, rsp_rend_ff;

   logic [BIW-1:0]   kx;
   logic             last_k;
   logic [WW-1:0]    cx;
   logic             right_ok;
   logic             out_free;
   logic             mem_we;
   logic [AW-1:0]    waddr;
   err3_type         mem_wd;
   err3_type         v_k;
   err3_type         fa;
   logic signed [ERR_W:0] ext;
   err_type          e [3];
   logic signed [CH_W:0] e9;

   assign kx       = k_ff[BIW-1:0];
   assign last_k   = (k_ff == (q_n - FW'(1)));
   assign cx       = WW'(q_x0) + WW'(k_ff);
   assign right_ok = (cx + WW'(1)) < q_w;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_rd_idx = kx;
   assign q_pop    = (state_ff == BK_DONE);
   assign v_k      = v_ff[kx];
   assign fa       = rd_zero_ff ? '0 : rdata_ff;

   bced_dist u_dist (
      .color   (dist_color),
      .pal     (dist_pal),
      .dist_sq (dist_o)
   );

   // clamp paths, distance mux, dither arithmetic
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         eff_k[c*CH_W +: CH_W] = clamp_px($signed({v_k[c][ERR_W-1], v_k[c]}));
         ext = $signed({v_k[c][ERR_W-1], v_k[c]}) + $signed({icarry_ff[c][ERR_W-1], icarry_ff[c]});
         col_a[c*CH_W +: CH_W] = clamp_px(ext);
      end
      unique case (state_ff)
         BK_DIST: begin
            dist_color = eff_k;
            dist_pal   = PALETTE_RGB[IDX_W'(p_ff)];
         end
         BK_DA: begin
            dist_color = col_a;
            dist_pal   = PALETTE_RGB[IDX_W'(best_i_ff)];
         end
         default: begin
            dist_color = col_ff;
            dist_pal   = PALETTE_RGB[IDX_W'(best_j_ff)];
         end
      endcase

      pick     = (di_ff < dj_ff) ? best_i_ff : best_j_ff;
      pal_pick = PALETTE_RGB[IDX_W'(pick)];
      for (int c = 0; c < 3; c++) begin
         e9   = $signed({1'b0, col_ff[c*CH_W +: CH_W]}) - $signed({1'b0, pal_pick[c*CH_W +: CH_W]});
         e[c] = ERR_W'(e9);
         wdata[c]     = acc_a_ff[c] + e[c] * 14'sd3;
         acc_a_in[c]  = acc_b_ff[c] + e[c] * 14'sd5;
         acc_b_in[c]  = right_ok ? e[c] : '0;
         icarry_in[c] = right_ok ? e[c] * 14'sd7 : '0;
      end

      lane_in     = lane_ff;
      lane_in[kx] = dist_o;

      sum_in = '0;
      for (int l = 0; l < BLOCK_WIDTH; l++) begin
         sum_in = sum_in + SW'((rd_i_ff[l] < rd_j_ff[l]) ? rd_i_ff[l] : rd_j_ff[l]);
      end

      mem_we = 1'b0;
      waddr  = {!bank_ff, CW'(cx - WW'(1))};
      mem_wd = wdata;
      if (state_ff == BK_DC && out_free && cx != '0) begin
         mem_we = 1'b1;
      end else if (state_ff == BK_FLUSH) begin
         mem_we = 1'b1;
         waddr  = {!bank_ff, CW'(cx)};
         mem_wd = acc_a_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (q_avail) state_in = BK_START;
         BK_START: state_in = BK_LRD;
         BK_LRD:   state_in = BK_LWR;
         BK_LWR:   state_in = last_k ? BK_DIST : BK_LRD;
         BK_DIST:  if (last_k && p_ff == LAST_P) state_in = BK_SCORE;
         BK_SCORE: if (si_ff == LAST_P && sj_ff == LAST_P) state_in = BK_DRAIN;
         BK_DRAIN: if (!s1_valid_ff && !s2_valid_ff) state_in = BK_DA;
         BK_DA:    state_in = BK_DB;
         BK_DB:    state_in = BK_DC;
         BK_DC: begin
            if (out_free) begin
               if (!last_k) state_in = BK_DA;
               else if (q_flags.row_last) state_in = BK_FLUSH;
               else state_in = BK_DONE;
            end
         end
         BK_FLUSH: state_in = BK_DONE;
         BK_DONE:  state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         err_mem[waddr] <= mem_wd;
      end
      if (state_ff == BK_LRD) begin
         rdata_ff <= err_mem[{bank_ff, CW'(cx)}];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_DIST && last_k) begin
         dist_mem[p_ff] <= lane_in;
      end
      rd_i_ff <= dist_mem[si_ff];
      rd_j_ff <= dist_mem[sj_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         rcarry_ff    <= '0;
         acc_a_ff     <= '0;
         acc_b_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == BK_SCORE);
         s1_i_ff     <= si_ff;
         s1_j_ff     <= sj_ff;
         s2_valid_ff <= s1_valid_ff;
         sum_ff      <= sum_in;
         s2_i_ff     <= s1_i_ff;
         s2_j_ff     <= s1_j_ff;
         // first strict minimum in scan order
         if (s2_valid_ff && (!have_ff || sum_ff < best_ff)) begin
            have_ff   <= 1'b1;
            best_ff   <= sum_ff;
            best_i_ff <= s2_i_ff;
            best_j_ff <= s2_j_ff;
         end
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            BK_START: begin
               k_ff      <= '0;
               p_ff      <= '0;
               si_ff     <= '0;
               sj_ff     <= '0;
               lane_ff   <= '0;
               icarry_ff <= '0;
               have_ff   <= 1'b0;
               if (q_flags.frame) begin
                  cnt_ff[0] <= '0;
                  cnt_ff[1] <= '0;
                  rcarry_ff <= '0;
                  acc_a_ff  <= '0;
                  acc_b_ff  <= '0;
               end
            end
            BK_LRD: begin
               rd_zero_ff <= (cx >= cnt_ff[bank_ff]);
            end
            BK_LWR: begin
               for (int c = 0; c < 3; c++) begin
                  v_ff[kx][c] <= ERR_W'($signed({3'b000, q_rd_pix[c*CH_W +: CH_W], 4'b0000})
                                 + $signed({fa[c][ERR_W-1], fa[c]})
                                 + ((k_ff == '0) ? $signed({rcarry_ff[c][ERR_W-1], rcarry_ff[c]})
                                                 : 15'sd0));
               end
               k_ff <= last_k ? '0 : k_ff + FW'(1);
            end
            BK_DIST: begin
               if (last_k) begin
                  lane_ff <= '0;
                  k_ff    <= '0;
                  p_ff    <= p_ff + PW'(1);
               end else begin
                  lane_ff <= lane_in;
                  k_ff    <= k_ff + FW'(1);
               end
            end
            BK_SCORE: begin
               if (sj_ff == LAST_P) begin
                  if (si_ff != LAST_P) begin
                     si_ff <= si_ff + PW'(1);
                     sj_ff <= si_ff + PW'(1);
                  end
               end else begin
                  sj_ff <= sj_ff + PW'(1);
               end
            end
            BK_DA: begin
               col_ff <= col_a;
               di_ff  <= dist_o;
            end
            BK_DB: begin
               dj_ff <= dist_o;
            end
            BK_DC: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= IDX_W'(pick);
                  rsp_bend_ff  <= last_k;
                  rsp_rend_ff  <= last_k && q_flags.row_last;
                  icarry_ff    <= icarry_in;
                  acc_a_ff     <= acc_a_in;
                  acc_b_ff     <= acc_b_in;
                  if (!last_k) begin
                     k_ff <= k_ff + FW'(1);
                  end else if (!q_flags.row_last) begin
                     rcarry_ff <= icarry_in;
                  end
               end
            end
            BK_FLUSH: begin
               cnt_ff[!bank_ff] <= cx + WW'(1);
               bank_ff          <= !bank_ff;
               acc_a_ff         <= '0;
               acc_b_ff         <= '0;
               rcarry_ff        <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_idx_ff);
   assign rsp_tlast  = rsp_bend_ff;
   assign rsp_tuser  = rsp_rend_ff;

endmodule

/* src/block_constrained_error_diffusion_unit.sv */
// Top level of the block-constrained error diffusion unit: width register and wiring.
// Depends on bced_pkg, bced_front, bced_queue, bced_back.
//
// Pixels stream in raster order; each closed block of up to BLOCK_WIDTH pixels (a block also
// closes at row end) returns one palette index per pixel, tlast on the block's last word and
// tuser on the last word of a row. The front end gathers the next block while the back end works
// on the current one. Per block of n pixels the back end's time is set by the single shared
// distance unit, which serves one pixel-palette pair per cycle, and the pair search, which
// scores one pair per cycle; any output stall adds to it.
// Error rows live in a ping-pong memory with a fill count per bank, so no clearing pass runs
// after reset or frame start. Write image_width only while no block is in flight.
module block_constrained_error_diffusion_unit #(
   parameter int MAX_WIDTH    = 1024,
   parameter int BLOCK_WIDTH  = 8,
   parameter int PALETTE_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // red, green, blue
   input  logic        req_tuser,    // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // palette_index, zero fill
   output logic        rsp_tlast,    // block_end
   output logic        rsp_tuser,    // row_end
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data   // image_width
);
   import bced_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int FW  = $clog2(BLOCK_WIDTH + 1);
   localparam int BIW = $clog2(BLOCK_WIDTH);

   logic [10:0]    width_ff;
   logic [WW-1:0]  w_eff;

   logic           q_can_write, q_wr_en, q_push, q_avail, q_pop;
   logic [BIW-1:0] q_wr_idx, q_rd_idx;
   rgb_type        q_wr_pix, q_rd_pix;
   logic [FW-1:0]  q_n, q_rd_n;
   logic [CW-1:0]  q_x0, q_rd_x0;
   blk_flags_type  q_flags, q_rd_flags;
   logic [WW-1:0]  q_w, q_rd_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd320;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // zero or oversize width means full MAX_WIDTH
   assign w_eff = (width_ff == '0 || 32'(width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ff);

   bced_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .BLOCK_WIDTH (BLOCK_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .w_eff       (w_eff),
      .q_can_write (q_can_write),
      .q_wr_en     (q_wr_en),
      .q_wr_idx    (q_wr_idx),
      .q_wr_pix    (q_wr_pix),
      .q_push      (q_push),
      .q_n         (q_n),
      .q_x0        (q_x0),
      .q_flags     (q_flags),
      .q_w         (q_w)
   );

   bced_queue #(
      .MAX_WIDTH   (MAX_WIDTH),
      .BLOCK_WIDTH (BLOCK_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (q_wr_en),
      .wr_idx     (q_wr_idx),
      .wr_pix     (q_wr_pix),
      .push       (q_push),
      .push_n     (q_n),
      .push_x0    (q_x0),
      .push_flags (q_flags),
      .push_w     (q_w),
      .can_write  (q_can_write),
      .rd_idx     (q_rd_idx),
      .rd_pix     (q_rd_pix),
      .avail      (q_avail),
      .pop        (q_pop),
      .rd_n       (q_rd_n),
      .rd_x0      (q_rd_x0),
      .rd_flags   (q_rd_flags),
      .rd_w       (q_rd_w)
   );

   bced_back #(
      .MAX_WIDTH    (MAX_WIDTH),
      .BLOCK_WIDTH  (BLOCK_WIDTH),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_avail    (q_avail),
      .q_pop      (q_pop),
      .q_rd_idx   (q_rd_idx),
      .q_rd_pix   (q_rd_pix),
      .q_n        (q_rd_n),
      .q_x0       (q_rd_x0),
      .q_flags    (q_rd_flags),
      .q_w        (q_rd_w),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_row_end_closes_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("row end without block end");

   a_pop_needs_block: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_avail)
      else $error("back end released an empty slot");

   a_push_into_empty: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_avail |=> q_avail)
      else $error("closed block not visible to back end");

   a_stall_means_work: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_avail)
      else $error("front end stalled with no block queued");

endmodule

/* verif/tb_block_constrained_error_diffusion_unit.sv */
// Testbench for block_constrained_error_diffusion_unit: streams pixels, predicts palette words.
// Depends on the RTL top level and bced_pkg (pulled in through the DUT).
`timescale 1ns / 100ps

module tb_block_constrained_error_diffusion_unit;

   localparam int MAXW = 1024;
   localparam int BLKW = 8;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      logic [3:0] index;
      logic       blk_end;
      logic       row_end;
   } pick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   block_constrained_error_diffusion_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // palette, red / green / blue
   int pal_r [16] = '{0,0,0,0,128,128,128,128,192,0,0,0,255,255,255,255};
   int pal_g [16] = '{0,0,128,128,0,0,128,128,192,0,255,255,0,0,255,255};
   int pal_b [16] = '{0,128,0,128,0,128,0,128,192,255,0,255,0,255,0,255};

   // predictor state, values in 1/16 units
   int err_above [MAXW][3];
   int err_below [MAXW][3];
   int blk_acc [BLKW][3];
   int carry_right [3];
   int col_pos, blk_fill;
   int width_reg = 320;

   pick_type pick_q [$];
   int errors, n_pixels, n_words, burst_left;
   bit hold_req;

   function automatic int clamp16(int v);
      if (v < 0) return 0;
      v = v >>> 4;
      return (v > 255) ? 255 : v;
   endfunction

   function automatic int pal_dist(int r, int g, int b, int p);
      return (r - pal_r[p]) ** 2 + (g - pal_g[p]) ** 2 + (b - pal_b[p]) ** 2;
   endfunction

   task automatic predict_pixel(input logic [23:0] rgb, input logic fs);
      int w, x, n, x0, cx, pk, best, best_i, best_j, total, d1, d2, v;
      int eff [BLKW][3];
      int run [3];
      int col [3];
      int e;
      bit last;
      pick_type p;
      if (fs) begin
         foreach (err_above[i, c]) begin
            err_above[i][c] = 0;
            err_below[i][c] = 0;
         end
         carry_right = '{0, 0, 0};
         col_pos = 0;
         blk_fill = 0;
      end
      w = (width_reg == 0 || width_reg > MAXW) ? MAXW : width_reg;
      x = col_pos;
      for (int c = 0; c < 3; c++) begin
         v = int'(rgb[8*c +: 8]) * 16 + err_above[x][c];
         if (blk_fill == 0) v += carry_right[c];
         blk_acc[blk_fill][c] = v;
      end
      blk_fill++;
      last = (x + 1 >= w);
      if (!last && blk_fill < BLKW) begin
         col_pos = x + 1;
         return;
      end
      n = blk_fill;
      x0 = x + 1 - n;
      for (int k = 0; k < n; k++)
         for (int c = 0; c < 3; c++) eff[k][c] = clamp16(blk_acc[k][c]);
      best = -1; best_i = 0; best_j = 0;
      for (int i = 0; i < 16; i++)
         for (int j = i; j < 16; j++) begin
            total = 0;
            for (int k = 0; k < n; k++) begin
               d1 = pal_dist(eff[k][0], eff[k][1], eff[k][2], i);
               d2 = pal_dist(eff[k][0], eff[k][1], eff[k][2], j);
               total += (d1 < d2) ? d1 : d2;
            end
            if (best < 0 || total < best) begin
               best = total; best_i = i; best_j = j;
            end
         end
      run = '{0, 0, 0};
      for (int k = 0; k < n; k++) begin
         cx = x0 + k;
         for (int c = 0; c < 3; c++) col[c] = clamp16(blk_acc[k][c] + run[c]);
         pk = (pal_dist(col[0], col[1], col[2], best_i) <
               pal_dist(col[0], col[1], col[2], best_j)) ? best_i : best_j;
         for (int c = 0; c < 3; c++) begin
            e = col[c] - ((c == 0) ? pal_r[pk] : (c == 1) ? pal_g[pk] : pal_b[pk]);
            run[c] = (cx + 1 < w) ? 7 * e : 0;
            if (cx >= 1) err_below[cx-1][c] += 3 * e;
            err_below[cx][c] += 5 * e;
            if (cx + 1 < w) err_below[cx+1][c] += e;
         end
         p.index = pk[3:0];
         p.blk_end = (k + 1 == n);
         p.row_end = (k + 1 == n) && last;
         pick_q.push_back(p);
      end
      blk_fill = 0;
      if (last) begin
         foreach (err_above[i, c]) begin
            err_above[i][c] = err_below[i][c];
            err_below[i][c] = 0;
         end
         carry_right = '{0, 0, 0};
         col_pos = 0;
      end else begin
         carry_right = run;
         col_pos = x + 1;
      end
   endtask

   // input monitor feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         n_pixels++;
         predict_pixel(req_tdata, req_tuser);
      end
   end

   // result checker
   always @(posedge clock) begin
      pick_type p;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_words++;
         if (pick_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word idx=%0d last=%b user=%b", $realtime,
                     rsp_tdata[3:0], rsp_tlast, rsp_tuser);
         end else begin
            p = pick_q.pop_front();
            if (rsp_tdata !== {4'b0, p.index} || rsp_tlast !== p.blk_end ||
                rsp_tuser !== p.row_end) begin
               errors++;
               $display("%0t: mismatch expected idx=%0d last=%b user=%b, got data=%0h last=%b user=%b",
                        $realtime, p.index, p.blk_end, p.row_end, rsp_tdata, rsp_tlast,
                        rsp_tuser);
            end
         end
      end
   end

   // receiver: stall pattern picked at random from four modes; long hold on request
   int rx_cyc, rx_mode, hold_cnt;
   always @(negedge clock) begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = 700;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((rx_cyc % 7) < 4);
         endcase
      end
   end

   // watchdog on cycles without any handshake
   int idle_cyc;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WD_LIMIT) begin
         $display("block_constrained_error_diffusion_unit test failed");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(input logic [23:0] rgb, input logic fs);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rgb;
      req_tuser <= fs;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
   endtask

   // all words in, then room for a block still in flight
   task automatic drain();
      end_burst();
      while (pick_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_width(input logic [10:0] w);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_reg = w;
      @(negedge clock);
   endtask

   function automatic logic [23:0] rand_pixel();
      logic [23:0] v;
      case ($urandom_range(0, 4))
         0: v = {8{3'b0}} | {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                             $urandom_range(0, 1) ? 8'hFF : 8'h00,
                             $urandom_range(0, 1) ? 8'hFF : 8'h00};
         1: v = {8'($urandom_range(96, 200)), 8'($urandom_range(96, 200)),
                 8'($urandom_range(96, 200))};
         default: v = 24'($urandom());
      endcase
      return v;
   endfunction

   task automatic test_extremes();
      logic [23:0] px [10] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                               24'hC0C0C0, 24'h808080, 24'h7F7F7F, 24'h010203, 24'hFEFDFC};
      for (int i = 0; i < 10; i++) send_pixel(px[i], i == 0);
      drain();
   endtask

   task automatic test_row_edges();
      write_width(11'd1);
      for (int i = 0; i < 3; i++) send_pixel(24'hFFFFFF >> (8 * i), i == 0);
      drain();
      write_width(11'd5);
      for (int i = 0; i < 6; i++) send_pixel(24'($urandom()), i == 0);
      drain();
   endtask

   // frame start mid-block drops the pending pixels
   task automatic test_frame_restart();
      for (int i = 0; i < 3; i++) send_pixel(24'($urandom()), 1'b0);
      send_pixel(24'h404040, 1'b1);
      for (int i = 0; i < 4; i++) send_pixel(24'($urandom()), 1'b0);
      drain();
   endtask

   // width lowered below the current column ends the row at the next pixel
   task automatic test_width_lowered();
      write_width(11'd20);
      for (int i = 0; i < 12; i++) send_pixel(24'($urandom()), i == 0);
      drain();
      write_width(11'd10);
      send_pixel(24'($urandom()), 1'b0);
      drain();
   endtask

   task automatic test_random();
      logic [10:0] widths [10] = '{11'd13, 11'd1024, 11'd0, 11'd2047, 11'd8, 11'd1,
                                   11'd3, 11'd9, 11'd17, 11'd16};
      int cnt;
      for (int ph = 0; ph < 10; ph++) begin
         write_width(ph < 10 ? widths[ph] : 11'($urandom_range(2, 40)));
         if (ph == 0) hold_req = 1'b1;
         cnt = (ph == 0) ? 60 : 20;
         for (int i = 0; i < cnt; i++)
            send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 39) == 0);
         drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_row_edges();
      test_frame_restart();
      test_width_lowered();
      test_random();
      $display("Covered %0d pixels and %0d palette words over widths 1 to max, out-of-range",
               n_pixels, n_words);
      $display("widths, frame restarts, a mid-row width drop and a long output stall.");
      if (errors == 0 && pick_q.size() == 0) begin
         $display("block_constrained_error_diffusion_unit test passed");
      end else begin
         $display("block_constrained_error_diffusion_unit test failed");
      end
      $finish;
   end

endmodule
